FILE: hdl/iir_scale_weight_trend_top_defines.svh
// Assertion macros shared by the checker.
`ifndef IIR_SCALE_WEIGHT_TREND_TOP_DEFINES_SVH
`define IIR_SCALE_WEIGHT_TREND_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SWT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define SWT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: hdl/iswt_pkg.sv
`default_nettype none
package iswt_pkg;

   localparam int FilterOrder  = 4;
   localparam int SampleBits   = 10;
   localparam int CoefBits     = 16;
   localparam int CoefFracBits = 14;
   localparam int OutFracBits  = 6;
   localparam int HistBits     = 24;
   localparam int OpBits       = HistBits + 1;
   localparam int ProdBits     = OpBits + CoefBits;
   localparam int AccBits      = ProdBits + 1;
   localparam int WeightBits   = 16;
   localparam int KgBits       = 8;
   localparam int NumBack      = 4;
   localparam int MacSteps     = 2 * FilterOrder + 1;
   localparam int StepBits     = $clog2(MacSteps);
   localparam int CsrIndexBits = 3;

   // configuration register indexes
   localparam logic [CsrIndexBits-1:0] RegFeedOuter  = 3'd0;
   localparam logic [CsrIndexBits-1:0] RegFeedInner  = 3'd1;
   localparam logic [CsrIndexBits-1:0] RegFeedCenter = 3'd2;
   localparam logic [CsrIndexBits-1:0] RegBackOne    = 3'd3;
   localparam logic [CsrIndexBits-1:0] RegBackTwo    = 3'd4;
   localparam logic [CsrIndexBits-1:0] RegBackThree  = 3'd5;
   localparam logic [CsrIndexBits-1:0] RegBackFour   = 3'd6;
   localparam logic [CsrIndexBits-1:0] RegFullScale  = 3'd7;

   // trend codes
   localparam logic [1:0] TrendSame = 2'd0;
   localparam logic [1:0] TrendUp   = 2'd1;
   localparam logic [1:0] TrendDown = 2'd2;

   typedef struct packed {
      logic                load;      // capture sample, clear accumulator
      logic                mul_en;    // multiply operands of step sel
      logic [StepBits-1:0] sel;
      logic                acc_en;    // add product into accumulator
      logic                round_en;  // round, saturate, shift histories
      logic                scale_en;  // clamp and scale to weight
      logic                out_load;  // load result registers
   } dp_cmd_type;

endpackage
`default_nettype wire

FILE: hdl/iswt_datapath.sv
`default_nettype none
module iswt_datapath
   import iswt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dp_cmd_type              cmd,
   input  wire logic [SampleBits-1:0]   adc_sample,
   input  wire logic                    csr_we,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CoefBits-1:0]     csr_data,
   output logic [SampleBits-1:0]        filtered_sample,
   output logic [WeightBits-1:0]        weight_q8,
   output logic [1:0]                   trend,
   output logic                         display_update
);

   localparam logic signed [AccBits-1:0] RoundHalf = AccBits'(1) <<< (CoefFracBits - 1);
   localparam logic signed [AccBits-1:0] HistMax   = AccBits'((1 << (HistBits - 1)) - 1);
   localparam logic signed [AccBits-1:0] HistMin   = -(AccBits'(1) <<< (HistBits - 1));
   localparam logic [HistBits-1:0]       SampleMax = HistBits'((1 << SampleBits) - 1);

   logic signed [CoefBits-1:0] feed_outer_ff, feed_inner_ff, feed_center_ff;
   logic signed [CoefBits-1:0] back_ff [NumBack];
   logic [WeightBits-1:0]      full_scale_ff;

   logic [SampleBits-1:0]      in_hist_ff  [FilterOrder];
   logic signed [HistBits-1:0] out_hist_ff [FilterOrder];
   logic [KgBits-1:0]          last_kg_ff, last_kg_in;

   logic [SampleBits-1:0]      sample_ff;
   logic signed [OpBits-1:0]   op_a;
   logic signed [CoefBits-1:0] op_b;
   logic signed [ProdBits-1:0] prod_ff, prod_in;
   logic signed [AccBits-1:0]  acc_ff, acc_in;
   logic signed [AccBits-1:0]  acc_rnd, y_full;
   logic signed [HistBits-1:0] y_ff, y_in, y_int;
   logic [SampleBits-1:0]      filt_ff, filt_in;
   logic [SampleBits+WeightBits-1:0] scale_prod;
   logic [WeightBits-1:0]      weight_ff, weight_in;
   logic [KgBits-1:0]          whole_kg;
   logic [1:0]                 trend_ff, trend_in;
   logic                       update_ff, update_in;
   logic [SampleBits-1:0]      filt_out_ff;
   logic [WeightBits-1:0]      weight_out_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_outer_ff  <= 16'sd2027;
         feed_inner_ff  <= 16'sd8108;
         feed_center_ff <= 16'sd12162;
         back_ff[0]     <= -16'sd5843;
         back_ff[1]     <= -16'sd8621;
         back_ff[2]     <= -16'sd1254;
         back_ff[3]     <= -16'sd330;
         full_scale_ff  <= 16'd7680;
      end else if (csr_we) begin
         unique case (csr_index)
            RegFeedOuter:  feed_outer_ff  <= csr_data;
            RegFeedInner:  feed_inner_ff  <= csr_data;
            RegFeedCenter: feed_center_ff <= csr_data;
            RegBackOne:    back_ff[0]     <= csr_data;
            RegBackTwo:    back_ff[1]     <= csr_data;
            RegBackThree:  back_ff[2]     <= csr_data;
            RegBackFour:   back_ff[3]     <= csr_data;
            RegFullScale:  full_scale_ff  <= csr_data;
            default:       ;
         endcase
      end
   end

   // operand select: steps 0..4 feed taps, 5..8 feedback taps
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.sel)
         4'd0: begin
            op_a = OpBits'({sample_ff, {OutFracBits{1'b0}}});
            op_b = feed_outer_ff;
         end
         4'd1: begin
            op_a = OpBits'({in_hist_ff[0], {OutFracBits{1'b0}}});
            op_b = feed_inner_ff;
         end
         4'd2: begin
            op_a = OpBits'({in_hist_ff[1], {OutFracBits{1'b0}}});
            op_b = feed_center_ff;
         end
         4'd3: begin
            op_a = OpBits'({in_hist_ff[2], {OutFracBits{1'b0}}});
            op_b = feed_inner_ff;
         end
         4'd4: begin
            op_a = OpBits'({in_hist_ff[3], {OutFracBits{1'b0}}});
            op_b = feed_outer_ff;
         end
         4'd5: begin
            op_a = {out_hist_ff[0][HistBits-1], out_hist_ff[0]};
            op_b = back_ff[0];
         end
         4'd6: begin
            op_a = {out_hist_ff[1][HistBits-1], out_hist_ff[1]};
            op_b = back_ff[1];
         end
         4'd7: begin
            op_a = {out_hist_ff[2][HistBits-1], out_hist_ff[2]};
            op_b = back_ff[2];
         end
         4'd8: begin
            op_a = {out_hist_ff[3][HistBits-1], out_hist_ff[3]};
            op_b = back_ff[3];
         end
         default: ;
      endcase
   end

   assign prod_in = op_a * op_b;
   assign acc_in  = cmd.load ? '0 : acc_ff + {prod_ff[ProdBits-1], prod_ff};

   // round half up, floor shift, saturate to history width
   assign acc_rnd = acc_ff + RoundHalf;
   assign y_full  = acc_rnd >>> CoefFracBits;
   always_comb begin
      if (y_full > HistMax)      y_in = HistMax[HistBits-1:0];
      else if (y_full < HistMin) y_in = HistMin[HistBits-1:0];
      else                       y_in = y_full[HistBits-1:0];
   end

   // clamp integer part to sample range, then scale
   assign y_int = y_ff >>> OutFracBits;
   always_comb begin
      if (y_int[HistBits-1])           filt_in = '0;
      else if (y_int > $signed(SampleMax)) filt_in = SampleMax[SampleBits-1:0];
      else                             filt_in = y_int[SampleBits-1:0];
   end
   assign scale_prod = filt_in * full_scale_ff;
   assign weight_in  = scale_prod[SampleBits +: WeightBits];

   assign whole_kg = weight_ff[WeightBits-1 -: KgBits];
   always_comb begin
      trend_in   = TrendSame;
      update_in  = 1'b0;
      last_kg_in = last_kg_ff;
      if (whole_kg != last_kg_ff) begin
         trend_in   = (whole_kg > last_kg_ff) ? TrendUp : TrendDown;
         update_in  = 1'b1;
         last_kg_in = whole_kg;
      end
   end

   // state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FilterOrder; i++) begin
            in_hist_ff[i]  <= '0;
            out_hist_ff[i] <= '0;
         end
         last_kg_ff <= '0;
      end else begin
         if (cmd.round_en) begin
            for (int i = FilterOrder - 1; i > 0; i--) begin
               in_hist_ff[i]  <= in_hist_ff[i-1];
               out_hist_ff[i] <= out_hist_ff[i-1];
            end
            in_hist_ff[0]  <= sample_ff;
            out_hist_ff[0] <= y_in;
         end
         if (cmd.out_load) last_kg_ff <= last_kg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load)                   sample_ff <= adc_sample;
      if (cmd.mul_en)                 prod_ff   <= prod_in;
      if (cmd.load || cmd.acc_en)     acc_ff    <= acc_in;
      if (cmd.round_en)               y_ff      <= y_in;
      if (cmd.scale_en) begin
         filt_ff   <= filt_in;
         weight_ff <= weight_in;
      end
      if (cmd.out_load) begin
         filt_out_ff   <= filt_ff;
         weight_out_ff <= weight_ff;
         trend_ff      <= trend_in;
         update_ff     <= update_in;
      end
   end

   assign filtered_sample = filt_out_ff;
   assign weight_q8       = weight_out_ff;
   assign trend           = trend_ff;
   assign display_update  = update_ff;

endmodule
`default_nettype wire

FILE: hdl/iswt_ctrl.sv
`default_nettype none
module iswt_ctrl
   import iswt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_LAST, ST_ROUND, ST_SCALE, ST_DONE
   } state_type;

   localparam logic [StepBits-1:0] LastStep = StepBits'(MacSteps - 1);

   state_type           state_ff, state_in;
   logic [StepBits-1:0] step_ff, step_in;
   logic                acc_en_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.mul_en   = (state_ff == ST_MAC);
      cmd.sel      = step_ff;
      cmd.acc_en   = acc_en_ff;
      cmd.round_en = (state_ff == ST_ROUND);
      cmd.scale_en = (state_ff == ST_SCALE);
      cmd.out_load = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) state_in = ST_MAC;
         end
         ST_MAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) state_in = ST_LAST;
         end
         ST_LAST:  state_in = ST_ROUND;
         ST_ROUND: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         acc_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         acc_en_ff    <= cmd.mul_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: hdl/iir_scale_weight_trend_top.sv
// Load-cell weight filter with whole-kg trend detection.
// Input channel req_*: one 10-bit ADC sample per item, accepted when
//   req_valid is high and req_stall is low.
// Result channel rsp_*: one item per input item carrying the clamped filter
//   output, the weight in 1/256 kg, the trend code and the update flag.
// Config channel csr_*: csr_ready is always high; index 0..7 selects the
//   coefficient or full-scale register. Write only while the block is idle.
// Datapath: one shared 25x16 multiplier works through nine taps, one per cycle.
// The filter loop (nine MAC steps, rounding, scaling, compare) runs one item
//   at a time; req_stall stays high until its result is loaded for output.
// A new item can be accepted while the previous result waits in the output
//   register; if rsp_stall is still high when the next result is ready,
//   the block holds it and keeps req_stall high until the old one leaves.
// Reset (synchronous, active high) restores default coefficients, clears
//   sample and output history, last whole-kg value and rsp_valid.
`default_nettype none
module iir_scale_weight_trend_top
   import iswt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [SampleBits-1:0]   req_adc_sample,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [SampleBits-1:0]        rsp_filtered_sample,
   output logic [WeightBits-1:0]        rsp_weight_q8,
   output logic [1:0]                   rsp_trend,
   output logic                         rsp_display_update,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CoefBits-1:0]     csr_data
);

   dp_cmd_type cmd;

   // config writes always taken
   assign csr_ready = 1'b1;

   iswt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   iswt_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .adc_sample      (req_adc_sample),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .filtered_sample (rsp_filtered_sample),
      .weight_q8       (rsp_weight_q8),
      .trend           (rsp_trend),
      .display_update  (rsp_display_update)
   );

endmodule
`default_nettype wire

FILE: hdl/iswt_checker.sv
`default_nettype none
`include "iir_scale_weight_trend_top_defines.svh"
module iswt_checker
   import iswt_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_trend,
   input wire logic       rsp_display_update
);

   // a stalled result stays offered
   `SWT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // one item in flight: an accept closes the input for the next cycle
   `SWT_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   // update flag goes with a nonzero trend
   `SWT_ASSERT_IMP(a_update_trend, clock, reset, rsp_valid, rsp_display_update == (rsp_trend != TrendSame))
   // trend never shows the unused code
   `SWT_ASSERT_IMP(a_trend_code, clock, reset, rsp_valid, rsp_trend != 2'd3)

endmodule

bind iir_scale_weight_trend_top iswt_checker u_iswt_checker (.*);
`default_nettype wire
